// ----- src/lzss_stream_decompressor_macros.svh -----
// Assertion macros used by the checker file.
`ifndef LZSS_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZSS_STREAM_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LZSS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lzss assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LZSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lzss assertion failed");

`endif

// ----- src/lzss_pkg.sv -----
// Shared constants and types of the LZSS stream decompressor.
package lzss_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int LEN_W        = 5;
  localparam int ITEMS_W      = 4;
  localparam int COUNT_W      = 32;

  localparam logic [LEN_W-1:0]   LEN_BIAS   = LEN_W'(3);
  localparam logic [ITEMS_W-1:0] FLAG_ITEMS = ITEMS_W'(8);

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  typedef struct packed {
    logic              we;
    logic [WIN_AW-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [WIN_AW-1:0] raddr;
  } lzss_ram_req_t;

endpackage

// ----- src/lzss_stream_decompressor.sv -----
// A literal result is registered and appears in the cycle after accept. A back-reference emits
// each byte by a history memory read, then emit and write back; the emit waits while the output
// slot is full. Input is taken in idle with a free output slot, so no byte is taken while a pair
// is copied. After the end of stream report, every request is taken and dropped. Reset clears
// the parser state, count, limit and out_valid, not copy registers or history (no sweep needed).
module lzss_stream_decompressor (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_output_limit,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic [31:0] out_total_count
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_COPY_RD = 3'd1;
  localparam logic [2:0] S_COPY_WR = 3'd2;
  localparam logic [2:0] S_REPORT  = 3'd3;
  localparam logic [2:0] S_DONE    = 3'd4;

  localparam int AW = lzss_pkg::WIN_AW;
  localparam int CW = lzss_pkg::COUNT_W;
  localparam int LW = lzss_pkg::LEN_W;
  localparam int IW = lzss_pkg::ITEMS_W;

  logic [2:0]    state_r, state_nxt;
  logic [7:0]    flag_r, flag_nxt;
  logic [IW-1:0] items_r, items_nxt;
  logic          pend_r, pend_nxt;
  logic [7:0]    first_r, first_nxt;
  logic [CW-1:0] prod_r, prod_nxt;
  logic [CW-1:0] limit_r;
  logic [AW-1:0] off_r, off_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          last_r, last_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic          out_kind_r, out_kind_nxt;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_run_last_r, out_run_last_nxt;
  logic [CW-1:0] out_total_r, out_total_nxt;

  lzss_pkg::lzss_ram_req_t ram_req;
  logic [7:0]              ram_rd;

  logic          slot_free;
  logic [AW-1:0] pair_off;
  logic          last_byte;
  logic [7:0]    copy_val;

  lzss_hist_ram u_hist (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = ((state_r == S_IDLE) && slot_free) || (state_r == S_DONE);
  assign cfg_ready = 1'b1;

  assign pair_off  = {first_r[3:0], in_byte};
  assign last_byte = ((cnt_r + LW'(1)) == len_r) || ((prod_r + CW'(1)) == limit_r);
  assign copy_val  = (prod_r >= {{(CW-AW){1'b0}}, off_r}) ? ram_rd : 8'd0;

  always_comb begin
    state_nxt        = state_r;
    flag_nxt         = flag_r;
    items_nxt        = items_r;
    pend_nxt         = pend_r;
    first_nxt        = first_r;
    prod_nxt         = prod_r;
    off_nxt          = off_r;
    len_nxt          = len_r;
    cnt_nxt          = cnt_r;
    last_nxt         = last_r;
    out_valid_nxt    = out_valid_r && !out_ready;
    out_kind_nxt     = out_kind_r;
    out_byte_nxt     = out_byte_r;
    out_run_last_nxt = out_run_last_r;
    out_total_nxt    = out_total_r;
    ram_req          = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && slot_free) begin
          if (items_r == '0) begin
            flag_nxt  = in_byte;
            items_nxt = lzss_pkg::FLAG_ITEMS;
            if (in_last) begin
              state_nxt = S_REPORT;
            end
          end else if (flag_r[7]) begin
            if (prod_r >= limit_r) begin
              state_nxt = S_REPORT;
            end else begin
              out_valid_nxt    = 1'b1;
              out_kind_nxt     = lzss_pkg::KIND_DATA;
              out_byte_nxt     = in_byte;
              out_run_last_nxt = !in_last;
              out_total_nxt    = prod_r + CW'(1);
              ram_req.we       = 1'b1;
              ram_req.waddr    = prod_r[AW-1:0];
              ram_req.wdata    = in_byte;
              prod_nxt         = prod_r + CW'(1);
              flag_nxt         = {flag_r[6:0], 1'b0};
              items_nxt        = items_r - IW'(1);
              if (in_last) begin
                state_nxt = S_REPORT;
              end
            end
          end else if (!pend_r) begin
            if (in_last) begin
              state_nxt = S_REPORT;
            end else begin
              first_nxt = in_byte;
              pend_nxt  = 1'b1;
            end
          end else begin
            pend_nxt = 1'b0;
            if (pair_off == '0) begin
              state_nxt = S_REPORT;
            end else begin
              off_nxt   = pair_off;
              len_nxt   = {1'b0, first_r[7:4]} + lzss_pkg::LEN_BIAS;
              cnt_nxt   = '0;
              last_nxt  = in_last;
              flag_nxt  = {flag_r[6:0], 1'b0};
              items_nxt = items_r - IW'(1);
              state_nxt = S_COPY_RD;
            end
          end
        end
      end
      S_COPY_RD: begin
        if (prod_r >= limit_r) begin
          state_nxt = last_r ? S_REPORT : S_IDLE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = prod_r[AW-1:0] - off_r;
          state_nxt     = S_COPY_WR;
        end
      end
      S_COPY_WR: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = lzss_pkg::KIND_DATA;
          out_byte_nxt     = copy_val;
          out_run_last_nxt = last_byte && !last_r;
          out_total_nxt    = prod_r + CW'(1);
          ram_req.we       = 1'b1;
          ram_req.waddr    = prod_r[AW-1:0];
          ram_req.wdata    = copy_val;
          prod_nxt         = prod_r + CW'(1);
          cnt_nxt          = cnt_r + LW'(1);
          if (last_byte) begin
            state_nxt = last_r ? S_REPORT : S_IDLE;
          end else begin
            state_nxt = S_COPY_RD;
          end
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = lzss_pkg::KIND_REPORT;
          out_byte_nxt     = 8'd0;
          out_run_last_nxt = 1'b1;
          out_total_nxt    = prod_r;
          state_nxt        = S_DONE;
        end
      end
      S_DONE: begin
        state_nxt = S_DONE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flag_r      <= '0;
      items_r     <= '0;
      pend_r      <= 1'b0;
      first_r     <= '0;
      prod_r      <= '0;
      limit_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flag_r      <= flag_nxt;
      items_r     <= items_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      prod_r      <= prod_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        limit_r <= cfg_output_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    off_r          <= off_nxt;
    len_r          <= len_nxt;
    cnt_r          <= cnt_nxt;
    last_r         <= last_nxt;
    out_kind_r     <= out_kind_nxt;
    out_byte_r     <= out_byte_nxt;
    out_run_last_r <= out_run_last_nxt;
    out_total_r    <= out_total_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte        = out_byte_r;
  assign out_run_last    = out_run_last_r;
  assign out_total_count = out_total_r;

endmodule

// ----- src/lzss_hist_ram.sv -----
// History window memory: one write port, one registered read port.
module lzss_hist_ram (
  input  logic                  clk,
  input  lzss_pkg::lzss_ram_req_t req,
  output logic [7:0]            rd_data
);

  logic [7:0] mem [lzss_pkg::WINDOW_DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data_r <= mem[req.raddr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/lzss_checker.sv -----
// Port-level checker for the LZSS stream decompressor, bound to the top level.
`include "lzss_stream_decompressor_macros.svh"

module lzss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_byte,
  input logic        out_run_last,
  input logic [31:0] out_total_count
);

  `LZSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_total_count) && $stable(out_kind))
  `LZSS_ASSERT_NOW(a_report_closes_run, clk, rst_n, out_valid && out_kind, out_run_last)
  `LZSS_ASSERT_NOW(a_report_zero_byte, clk, rst_n, out_valid && out_kind, out_byte == 8'd0)
  `LZSS_ASSERT_NEXT(a_silent_after_report, clk, rst_n, out_valid && out_ready && out_kind, !out_valid)

endmodule

bind lzss_stream_decompressor lzss_checker u_lzss_checker (.*);

// ----- tb/tb_lzss_stream_decompressor.sv -----
// Self-checking testbench of the LZSS stream decompressor: one stream, checked byte by byte.
module tb_lzss_stream_decompressor;

  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT   = 2000;
  localparam logic [31:0] LIMIT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic        run_last;
    logic [31:0] count;
  } decoded_t;

  typedef enum int {
    END_ON_FLAG,
    END_ON_LITERAL,
    END_ON_PAIR,
    END_SPLIT_PAIR,
    END_ZERO_OFFSET,
    END_LIMIT_LITERAL
  } end_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_output_limit = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic [31:0] out_total_count;

  // predictor state
  logic [7:0]  win_mem [lzss_pkg::WINDOW_DEPTH];
  logic [7:0]  flag_sr = '0;
  logic [3:0]  slots_left = '0;
  logic        half_pair = 1'b0;
  logic [7:0]  pair_hi = '0;
  logic [31:0] decoded_total = '0;
  logic        finished = 1'b0;
  logic [31:0] limit_reg = '0;

  decoded_t    decoded_q[$];
  decoded_t    want;
  logic [11:0] planned_offset = 12'd1;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          fail_count = 0;
  int          stall_cycles = 0;

  lzss_stream_decompressor u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_output_limit(cfg_output_limit),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_total_count (out_total_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual kind %0b byte %0h count %0d",
                 $time, out_kind, out_byte, out_total_count);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_kind));
        check_field("byte", 32'(want.data), 32'(out_byte));
        check_field("run_last", 32'(want.run_last), 32'(out_run_last));
        check_field("total_count", want.count, out_total_count);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, stall_cycles);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic emit_byte(input logic [7:0] v);
    decoded_t r;
    win_mem[decoded_total[11:0]] = v;
    decoded_total = decoded_total + 32'd1;
    r.kind = lzss_pkg::KIND_DATA;
    r.data = v;
    r.run_last = 1'b0;
    r.count = decoded_total;
    decoded_q.push_back(r);
  endtask

  task automatic next_slot();
    flag_sr = flag_sr << 1;
    if (slots_left != 0) slots_left = slots_left - 4'd1;
  endtask

  task automatic predict_decode(input logic [7:0] b, input logic last);
    logic [11:0] off;
    logic [31:0] back;
    logic [7:0]  v;
    int          len;
    int          base;
    logic        stop;
    decoded_t    r;
    if (finished) return;
    base = decoded_q.size();
    stop = 1'b0;
    if (slots_left == 0) begin
      flag_sr = b;
      slots_left = lzss_pkg::FLAG_ITEMS;
      stop = last;
    end else if (flag_sr[7]) begin
      if (decoded_total >= limit_reg) begin
        stop = 1'b1;
      end else begin
        emit_byte(b);
        next_slot();
        stop = last;
      end
    end else if (!half_pair) begin
      if (last) begin
        stop = 1'b1;
      end else begin
        pair_hi = b;
        half_pair = 1'b1;
      end
    end else begin
      off = {pair_hi[3:0], b};
      half_pair = 1'b0;
      if (off == 12'd0) begin
        stop = 1'b1;
      end else begin
        len = int'(pair_hi[7:4]) + int'(lzss_pkg::LEN_BIAS);
        for (int c = 0; c < len && decoded_total < limit_reg; c++) begin
          v = 8'h00;
          if (decoded_total >= 32'(off)) begin
            back = decoded_total - 32'(off);
            v = win_mem[back[11:0]];
          end
          emit_byte(v);
        end
        next_slot();
        stop = last;
      end
    end
    if (stop) begin
      finished = 1'b1;
      r.kind = lzss_pkg::KIND_REPORT;
      r.data = 8'h00;
      r.run_last = 1'b0;
      r.count = decoded_total;
      decoded_q.push_back(r);
    end
    if (decoded_q.size() > base) begin
      r = decoded_q.pop_back();
      r.run_last = 1'b1;
      decoded_q.push_back(r);
    end
  endtask

  task automatic send_request(input logic [7:0] b, input logic last);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    predict_decode(b, last);
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] v);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_output_limit <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    limit_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // well-formed next byte for the current parser position
  task automatic next_byte(input logic pair_only, output logic [7:0] b);
    int span;
    if (slots_left == 0) begin
      b = pair_only ? 8'h00 : 8'($urandom_range(0, 255));
    end else if (flag_sr[7]) begin
      b = 8'($urandom_range(0, 255));
    end else if (!half_pair) begin
      span = (decoded_total > 32'd4095) ? 4095 : int'(decoded_total);
      if (span == 0 || $urandom_range(0, 4) == 0) begin
        planned_offset = 12'($urandom_range(1, 4095));
      end else begin
        planned_offset = 12'($urandom_range(1, span));
      end
      b = {4'($urandom_range(0, 15)), planned_offset[11:8]};
    end else begin
      b = planned_offset[7:0];
    end
  endtask

  task automatic send_items(input int n, input logic pair_only, input logic pauses);
    logic [7:0] b;
    for (int i = 0; i < n || slots_left != 0; i++) begin
      if (pauses && $urandom_range(0, 29) == 0) drain();
      next_byte(pair_only, b);
      send_request(b, 1'b0);
    end
  endtask

  task automatic test_directed();
    write_limit(LIMIT_MAX);
    send_request(8'hE0, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hA5, 1'b0);
    send_request(8'hF0, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h0F, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h50, 1'b0);
    send_request(8'h03, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'h10, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(8'h55, 1'b0);
    send_request(8'hAA, 1'b0);
    send_request(8'h01, 1'b0);
    send_request(8'h80, 1'b0);
    send_request(8'h7F, 1'b0);
    send_request(8'hFE, 1'b0);
    send_request(8'h3C, 1'b0);
    send_request(8'hC3, 1'b0);
  endtask

  task automatic test_random_traffic(input int n);
    send_items(n, 1'b0, 1'b1);
  endtask

  task automatic test_clipped_copy();
    write_limit(decoded_total + 32'($urandom_range(1, 24)));
    send_items(34, 1'b1, 1'b0);
  endtask

  task automatic test_zero_limit();
    write_limit(32'd0);
    send_items(17, 1'b1, 1'b0);
  endtask

  task automatic test_end_of_stream();
    end_mode_t  ending;
    logic [7:0] b;
    ending = end_mode_t'($urandom_range(0, 5));
    case (ending)
      END_ON_FLAG: begin
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end
      END_ON_LITERAL: begin
        send_request(8'($urandom_range(0, 255)) | 8'h80, 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end
      END_ON_PAIR: begin
        send_request(8'($urandom_range(0, 255)) & 8'h7F, 1'b0);
        next_byte(1'b0, b);
        send_request(b, 1'b0);
        next_byte(1'b0, b);
        send_request(b, 1'b1);
      end
      END_SPLIT_PAIR: begin
        send_request(8'($urandom_range(0, 255)) & 8'h7F, 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b1);
      end
      END_ZERO_OFFSET: begin
        send_request(8'($urandom_range(0, 255)) & 8'h7F, 1'b0);
        send_request({4'($urandom_range(0, 15)), 4'h0}, 1'b0);
        send_request(8'h00, 1'b0);
      end
      default: begin
        write_limit(($urandom_range(0, 1) == 0) ? 32'd0 : decoded_total);
        send_request(8'($urandom_range(0, 255)) | 8'h80, 1'b0);
        send_request(8'($urandom_range(0, 255)), 1'b0);
      end
    endcase
    // drop everything after the report
    repeat (4) send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 57;
    test_directed();
    test_random_traffic(80);
    test_clipped_copy();

    send_idle_pct = 57;
    recv_idle_pct = 29;
    test_zero_limit();
    write_limit(decoded_total + 32'($urandom_range(5000, 1000000)));
    test_random_traffic(70);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limit(LIMIT_MAX);
    test_random_traffic(60);
    test_end_of_stream();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
